// ===== rtl/btd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the BER TLV stream deframer.
package btd_pkg;

	localparam int LEN_BITS_DEF    = 32;
	localparam int TAG_BITS_DEF    = 32;
	localparam int DEPTH_MAX_DEF   = 15;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] BYTE_80  = 8'h80;
	localparam logic [7:0] MASK_7F  = 8'h7F;
	localparam logic [4:0] TAG_LONG = 5'h1F;

	localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;

	typedef enum logic [2:0] {
		PH_ID   = 3'd0,
		PH_TAGC = 3'd1,
		PH_LEN  = 3'd2,
		PH_LENC = 3'd3,
		PH_CONT = 3'd4,
		PH_ERR  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_ID   = 3'd0,
		ROLE_TAGC = 3'd1,
		ROLE_LEN  = 3'd2,
		ROLE_LENC = 3'd3,
		ROLE_CONT = 3'd4,
		ROLE_ERR  = 3'd5
	} role_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_BAD_LEN = 3'd1,
		ERR_WIDE    = 3'd2,
		ERR_DEPTH   = 3'd3,
		ERR_TRUNC   = 3'd4
	} err_code_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
		logic       id_long;
		logic       is_ff;
		logic       is_80;
		logic       is_short;
	} item_t;

	typedef struct packed {
		role_t      byte_role;
		logic       header_done;
		logic [1:0] tag_class;
		logic       constructed;
		logic [31:0] tag_number;
		logic [31:0] content_length;
		logic       indefinite;
		logic [7:0] content_byte;
		logic       element_end;
		logic [3:0] nest_depth;
		err_code_t  error_code;
	} result_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_stat_t;

endpackage

// ===== rtl/btd_stream_if.sv =====
`timescale 1ns / 1ps
// Byte input and result output channel interfaces.
interface btd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source(output valid, data_byte, stream_end, input ready);
	modport sink(input valid, data_byte, stream_end, output ready);
endinterface

interface btd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic        header_done;
	logic [1:0]  tag_class;
	logic        constructed;
	logic [31:0] tag_number;
	logic [31:0] content_length;
	logic        indefinite;
	logic [7:0]  content_byte;
	logic        element_end;
	logic [3:0]  nest_depth;
	logic [2:0]  error_code;

	modport source(output valid, byte_role, header_done, tag_class, constructed, tag_number,
		content_length, indefinite, content_byte, element_end, nest_depth, error_code,
		input ready);
	modport sink(input valid, byte_role, header_done, tag_class, constructed, tag_number,
		content_length, indefinite, content_byte, element_end, nest_depth, error_code,
		output ready);
endinterface

// ===== rtl/ber_tlv_stream_deframer.sv =====
`timescale 1ns / 1ps
// Top level of the BER TLV stream deframer.
//
//  channel    modport  beat
//  byte_in    sink     data_byte, stream_end
//  role_out   source   one decoded result per input byte
//
// One byte per cycle sustained while role_out is ready; a byte's result passes
// through the input stage, the queue and the decoder output register.
// The decoder's header state update is the loop that sets the rate.
// Reset clears all control state, the queue and the sticky error.
// A stalled output holds the decoder; the queue then fills and drops byte_in.ready.
module ber_tlv_stream_deframer
	import btd_pkg::*;
#(
	parameter int LEN_BITS    = LEN_BITS_DEF,
	parameter int TAG_BITS    = TAG_BITS_DEF,
	parameter int DEPTH_MAX   = DEPTH_MAX_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	btd_in_if.sink     byte_in,
	btd_out_if.source  role_out
);

	queue_stat_t q_stat;
	logic        push;
	item_t       push_item;
	logic        pop;
	item_t       pop_item;
	result_t     res;

	btd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (byte_in.valid),
		.in_ready   (byte_in.ready),
		.data_byte  (byte_in.data_byte),
		.stream_end (byte_in.stream_end),
		.q_stat     (q_stat),
		.push       (push),
		.item       (push_item)
	);

	btd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	btd_back #(
		.LEN_BITS  (LEN_BITS),
		.TAG_BITS  (TAG_BITS),
		.DEPTH_MAX (DEPTH_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_stat.valid),
		.item       (pop_item),
		.pop        (pop),
		.res_valid  (role_out.valid),
		.res_ready  (role_out.ready),
		.res        (res)
	);

	assign role_out.byte_role      = res.byte_role;
	assign role_out.header_done    = res.header_done;
	assign role_out.tag_class      = res.tag_class;
	assign role_out.constructed    = res.constructed;
	assign role_out.tag_number     = res.tag_number;
	assign role_out.content_length = res.content_length;
	assign role_out.indefinite     = res.indefinite;
	assign role_out.content_byte   = res.content_byte;
	assign role_out.element_end    = res.element_end;
	assign role_out.nest_depth     = res.nest_depth;
	assign role_out.error_code     = res.error_code;

endmodule

// ===== rtl/btd_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts stream bytes and classifies them for the decoder.
module btd_front
	import btd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	input  queue_stat_t q_stat,
	output logic        push,
	output item_t       item
);

	logic  valid_s1;
	item_t item_s1;
	item_t cls;

	always_comb begin
		cls.data_byte  = data_byte;
		cls.stream_end = stream_end;
		cls.id_long    = (data_byte[4:0] == TAG_LONG);
		cls.is_ff      = (data_byte == BYTE_FF);
		cls.is_80      = (data_byte == BYTE_80);
		cls.is_short   = ((data_byte & ~MASK_7F) == 8'h00);
	end

	assign push     = valid_s1 && !q_stat.full;
	assign in_ready = !valid_s1 || !q_stat.full;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== rtl/btd_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified bytes between front and decoder.
module btd_fifo
	import btd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_t       push_item,
	input  logic        pop,
	output item_t       pop_item,
	output queue_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign pop_item   = mem[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/btd_back.sv =====
`timescale 1ns / 1ps
// Decoder: tracks the TLV header state and produces one result per byte.
module btd_back
	import btd_pkg::*;
#(
	parameter int LEN_BITS  = LEN_BITS_DEF,
	parameter int TAG_BITS  = TAG_BITS_DEF,
	parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  item_t   item,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int DW = $clog2(DEPTH_MAX + 1);

	phase_t              phase_q, n_phase;
	logic [1:0]          class_q, n_class;
	logic                cons_q, n_cons;
	logic                indef_q, n_indef;
	logic [TAG_BITS-1:0] tag_q, n_tag;
	logic [LEN_BITS-1:0] len_q, n_len;
	logic [6:0]          lbl_q, n_lbl;
	logic [LEN_BITS-1:0] cont_q, n_cont;
	logic [DW-1:0]       depth_q, n_depth;
	err_code_t           err_q, n_err;

	logic                hdr_go;
	logic                hdr_indef;
	logic [LEN_BITS-1:0] hdr_len;
	result_t             r;
	logic                ovld_q;
	result_t             res_q;

	assign pop       = item_valid && (!ovld_q || res_ready);
	assign res_valid = ovld_q;
	assign res       = res_q;

	always_comb begin
		n_phase = phase_q;
		n_class = class_q;
		n_cons  = cons_q;
		n_indef = indef_q;
		n_tag   = tag_q;
		n_len   = len_q;
		n_lbl   = lbl_q;
		n_cont  = cont_q;
		n_depth = depth_q;
		n_err   = err_q;
		hdr_go    = 1'b0;
		hdr_indef = 1'b0;
		hdr_len   = '0;
		r.byte_role    = ROLE_ERR;
		r.header_done  = 1'b0;
		r.element_end  = 1'b0;
		r.content_byte = 8'h00;

		case (phase_q)
			PH_ID: begin
				r.byte_role = ROLE_ID;
				n_class = item.data_byte[7:6];
				n_cons  = item.data_byte[5];
				n_indef = 1'b0;
				n_len   = '0;
				n_lbl   = '0;
				n_cont  = '0;
				if (item.id_long) begin
					n_tag   = '0;
					n_phase = PH_TAGC;
				end else begin
					n_tag   = TAG_BITS'(item.data_byte[4:0]);
					n_phase = PH_LEN;
				end
			end
			PH_TAGC: begin
				r.byte_role = ROLE_TAGC;
				if ((tag_q >> (TAG_BITS - 7)) != '0) begin
					n_err   = ERR_WIDE;
					n_phase = PH_ERR;
				end else begin
					n_tag = (tag_q << 7) | TAG_BITS'(item.data_byte[6:0]);
					if (!item.data_byte[7]) begin
						n_phase = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				r.byte_role = ROLE_LEN;
				if (item.is_ff) begin
					n_err   = ERR_BAD_LEN;
					n_phase = PH_ERR;
				end else if (item.is_short) begin
					hdr_go  = 1'b1;
					hdr_len = LEN_BITS'(item.data_byte[6:0]);
				end else if (item.is_80) begin
					hdr_go    = 1'b1;
					hdr_indef = 1'b1;
				end else begin
					n_len   = '0;
					n_lbl   = item.data_byte[6:0];
					n_phase = PH_LENC;
				end
			end
			PH_LENC: begin
				r.byte_role = ROLE_LENC;
				if ((len_q >> (LEN_BITS - 8)) != '0) begin
					n_err   = ERR_WIDE;
					n_phase = PH_ERR;
				end else begin
					n_len = (len_q << 8) | LEN_BITS'(item.data_byte);
					n_lbl = lbl_q - 7'd1;
					if (lbl_q == 7'd1) begin
						hdr_go  = 1'b1;
						hdr_len = (len_q << 8) | LEN_BITS'(item.data_byte);
					end
				end
			end
			PH_CONT: begin
				r.byte_role    = ROLE_CONT;
				r.content_byte = item.data_byte;
				n_cont = cont_q - LEN_BITS'(1);
				if (cont_q == LEN_BITS'(1)) begin
					r.element_end = 1'b1;
					n_phase       = PH_ID;
				end
			end
			default: begin
				n_phase = PH_ERR;
			end
		endcase

		if (hdr_go) begin
			r.header_done = 1'b1;
			n_indef       = hdr_indef;
			n_len         = hdr_len;
			if (hdr_indef) begin
				if (depth_q >= DW'(DEPTH_MAX)) begin
					n_err   = ERR_DEPTH;
					n_phase = PH_ERR;
				end else begin
					n_depth = depth_q + DW'(1);
					n_phase = PH_ID;
				end
			end else if (hdr_len == '0) begin
				r.element_end = 1'b1;
				if (class_q == CLASS_UNIVERSAL && !cons_q && tag_q == '0 && depth_q != '0) begin
					n_depth = depth_q - DW'(1);
				end
				n_phase = PH_ID;
			end else begin
				n_cont  = hdr_len;
				n_phase = PH_CONT;
			end
		end

		if (item.stream_end && n_phase != PH_ERR && (n_phase != PH_ID || n_depth != '0)) begin
			n_err   = ERR_TRUNC;
			n_phase = PH_ERR;
		end

		if (n_phase == PH_ERR) begin
			r.byte_role    = ROLE_ERR;
			r.header_done  = 1'b0;
			r.element_end  = 1'b0;
			r.content_byte = 8'h00;
		end

		r.tag_class      = n_class;
		r.constructed    = n_cons;
		r.tag_number     = 32'(n_tag);
		r.content_length = 32'(n_len);
		r.indefinite     = n_indef;
		r.nest_depth     = 4'(n_depth);
		r.error_code     = n_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			class_q <= '0;
			cons_q  <= 1'b0;
			indef_q <= 1'b0;
			tag_q   <= '0;
			len_q   <= '0;
			lbl_q   <= '0;
			cont_q  <= '0;
			depth_q <= '0;
			err_q   <= ERR_NONE;
			ovld_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= n_phase;
				class_q <= n_class;
				cons_q  <= n_cons;
				indef_q <= n_indef;
				tag_q   <= n_tag;
				len_q   <= n_len;
				lbl_q   <= n_lbl;
				cont_q  <= n_cont;
				depth_q <= n_depth;
				err_q   <= n_err;
			end
			if (pop) begin
				ovld_q <= 1'b1;
			end else if (res_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= r;
		end
	end

endmodule

// ===== rtl/btd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the deframer's result channel, bound to the top level.
module btd_checker
	import btd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] byte_role,
	input logic       header_done,
	input logic       element_end,
	input logic [7:0] content_byte,
	input logic [2:0] error_code
);

	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && byte_role == ROLE_ERR) begin
			err_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_role) && $stable(error_code))
		else $error("result beat changed while stalled");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err_seen_q |-> byte_role == ROLE_ERR)
		else $error("error state left before reset");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role == ROLE_ERR |->
			!header_done && !element_end && content_byte == 8'h00 && error_code != ERR_NONE)
		else $error("error beat carries element flags or no code");

	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role != ROLE_ERR |-> error_code == ERR_NONE)
		else $error("error code without error role");

endmodule

bind ber_tlv_stream_deframer btd_checker u_btd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (role_out.valid),
	.out_ready    (role_out.ready),
	.byte_role    (role_out.byte_role),
	.header_done  (role_out.header_done),
	.element_end  (role_out.element_end),
	.content_byte (role_out.content_byte),
	.error_code   (role_out.error_code)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the BER TLV stream deframer: random BER streams, predicted roles.
module tb_top;
	import btd_pkg::*;

	localparam int         CYCLE_LIMIT     = 500000;
	localparam int         RANDOM_BYTES    = 1900;
	localparam int         LONG_HOLD_AT    = 400;
	localparam int         LONG_HOLD_LEN   = 150;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} beat_t;

	typedef enum int {
		FAIL_BAD_LEN,
		FAIL_WIDE_TAG,
		FAIL_WIDE_LEN,
		FAIL_DEPTH,
		FAIL_TRUNC_HDR,
		FAIL_TRUNC_BODY,
		FAIL_TRUNC_OPEN
	} fail_kind_t;

	logic clk;
	logic arst_n;

	btd_in_if  bin();
	btd_out_if bout();

	ber_tlv_stream_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (bin),
		.role_out (bout)
	);

	beat_t   byte_q[$];
	result_t role_exp_q[$];
	int      bytes_pushed = 0;
	int      err_cnt      = 0;
	int      cycles       = 0;
	bit      calm         = 1'b0;

	phase_t      dec_phase;
	logic [1:0]  dec_class;
	logic        dec_cons;
	logic        dec_indef;
	logic [63:0] dec_tag;
	logic [63:0] dec_len;
	logic [6:0]  dec_len_left;
	logic [63:0] dec_remain;
	int unsigned dec_depth;
	err_code_t   dec_err;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void fail_decode(err_code_t code);
		dec_err   = code;
		dec_phase = PH_ERR;
	endfunction

	function automatic void finish_header(output logic hdr, output logic eoe);
		hdr = 1'b1;
		eoe = 1'b0;
		if (dec_indef) begin
			if (dec_depth >= DEPTH_MAX_DEF) begin
				fail_decode(ERR_DEPTH);
			end else begin
				dec_depth++;
				dec_phase = PH_ID;
			end
		end else if (dec_len == 0) begin
			eoe = 1'b1;
			if (dec_class == CLASS_UNIVERSAL && !dec_cons && dec_tag == 0 && dec_depth > 0)
				dec_depth--;
			dec_phase = PH_ID;
		end else begin
			dec_remain = dec_len;
			dec_phase  = PH_CONT;
		end
	endfunction

	function automatic result_t decode_byte(logic [7:0] b, logic se);
		result_t r;
		logic    hdr;
		logic    eoe;
		r = '0;
		hdr = 1'b0;
		eoe = 1'b0;
		r.byte_role = ROLE_ERR;
		case (dec_phase)
		PH_ID: begin
			r.byte_role  = ROLE_ID;
			dec_class    = b[7:6];
			dec_cons     = b[5];
			dec_indef    = 1'b0;
			dec_len      = '0;
			dec_len_left = '0;
			dec_remain   = '0;
			if (b[4:0] == TAG_LONG) begin
				dec_tag   = '0;
				dec_phase = PH_TAGC;
			end else begin
				dec_tag   = 64'(b[4:0]);
				dec_phase = PH_LEN;
			end
		end
		PH_TAGC: begin
			r.byte_role = ROLE_TAGC;
			if ((dec_tag >> (TAG_BITS_DEF - 7)) != 0) begin
				fail_decode(ERR_WIDE);
			end else begin
				dec_tag = (dec_tag << 7) | 64'(b & MASK_7F);
				if (!b[7])
					dec_phase = PH_LEN;
			end
		end
		PH_LEN: begin
			r.byte_role = ROLE_LEN;
			if (b == BYTE_FF) begin
				fail_decode(ERR_BAD_LEN);
			end else if (b < BYTE_80) begin
				dec_len = 64'(b);
				finish_header(hdr, eoe);
			end else if (b == BYTE_80) begin
				dec_indef = 1'b1;
				dec_len   = '0;
				finish_header(hdr, eoe);
			end else begin
				dec_len      = '0;
				dec_len_left = b[6:0];
				dec_phase    = PH_LENC;
			end
		end
		PH_LENC: begin
			r.byte_role = ROLE_LENC;
			if ((dec_len >> (LEN_BITS_DEF - 8)) != 0) begin
				fail_decode(ERR_WIDE);
			end else begin
				dec_len      = (dec_len << 8) | 64'(b);
				dec_len_left = dec_len_left - 7'd1;
				if (dec_len_left == 0)
					finish_header(hdr, eoe);
			end
		end
		PH_CONT: begin
			r.byte_role    = ROLE_CONT;
			r.content_byte = b;
			dec_remain     = dec_remain - 1;
			if (dec_remain == 0) begin
				eoe       = 1'b1;
				dec_phase = PH_ID;
			end
		end
		default: dec_phase = PH_ERR;
		endcase

		if (se && dec_phase != PH_ERR && (dec_phase != PH_ID || dec_depth != 0))
			fail_decode(ERR_TRUNC);

		if (dec_phase == PH_ERR) begin
			r.byte_role    = ROLE_ERR;
			r.content_byte = '0;
			hdr = 1'b0;
			eoe = 1'b0;
		end
		r.header_done    = hdr;
		r.tag_class      = dec_class;
		r.constructed    = dec_cons;
		r.tag_number     = dec_tag[31:0];
		r.content_length = dec_len[31:0];
		r.indefinite     = dec_indef;
		r.element_end    = eoe;
		r.nest_depth     = dec_depth[3:0];
		r.error_code     = dec_err;
		return r;
	endfunction

	function automatic int idle_share();
		case ($urandom_range(3))
		0: return 0;
		1: return 5;
		2: return 20;
		default: return 40;
		endcase
	endfunction

	function automatic logic [31:0] pick_tag();
		case ($urandom_range(7))
		0: return $urandom;
		1: return $urandom_range(300, 31);
		default: return $urandom_range(30);
		endcase
	endfunction

	task automatic push_byte(logic [7:0] b, logic se);
		beat_t bt;
		bt.data_byte  = b;
		bt.stream_end = se;
		byte_q.push_back(bt);
		bytes_pushed++;
	endtask

	task automatic end_stream();
		beat_t tail;
		tail = byte_q.pop_back();
		tail.stream_end = 1'b1;
		byte_q.push_back(tail);
	endtask

	task automatic put_ident(logic [1:0] cls, logic cons, logic [31:0] tag);
		int n;
		int pad;
		if (tag < 31 && $urandom_range(7) != 0) begin
			push_byte({cls, cons, tag[4:0]}, 1'b0);
		end else begin
			push_byte({cls, cons, TAG_LONG}, 1'b0);
			n = 1;
			for (int i = 1; i < 5; i++)
				if ((tag >> (7 * i)) != 0)
					n = i + 1;
			pad = ($urandom_range(7) == 0) ? $urandom_range(3, 1) : 0;
			repeat (pad) push_byte(BYTE_80, 1'b0);
			for (int i = n - 1; i >= 0; i--)
				push_byte({i != 0, 7'(tag >> (7 * i))}, 1'b0);
		end
	endtask

	task automatic put_any_ident();
		put_ident(2'($urandom_range(3)), 1'($urandom_range(1)), pick_tag());
	endtask

	task automatic put_length(int unsigned len);
		int n;
		int pad;
		if (len < 128 && $urandom_range(3) != 0) begin
			push_byte(8'(len), 1'b0);
		end else begin
			n = 1;
			for (int i = 1; i < 4; i++)
				if ((len >> (8 * i)) != 0)
					n = i + 1;
			if ($urandom_range(63) == 0)
				pad = 126 - n;
			else
				pad = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
			push_byte(BYTE_80 | 8'(n + pad), 1'b0);
			repeat (pad) push_byte(8'h00, 1'b0);
			for (int i = n - 1; i >= 0; i--)
				push_byte(8'(len >> (8 * i)), 1'b0);
		end
	endtask

	task automatic put_element(inout int depth);
		int          pick;
		logic [1:0]  cls;
		logic        cons;
		logic [31:0] tag;
		int unsigned len;
		pick = $urandom_range(9);
		if (depth > 0 && pick < 2) begin
			// end-of-contents, short or long length form
			push_byte(8'h00, 1'b0);
			put_length(0);
			depth--;
		end else begin
			cls  = 2'($urandom_range(3));
			cons = 1'($urandom_range(1));
			tag  = pick_tag();
			put_ident(cls, cons, tag);
			if (depth < DEPTH_MAX_DEF && pick < 4) begin
				push_byte(BYTE_80, 1'b0);
				depth++;
			end else begin
				len = ($urandom_range(31) == 0) ? $urandom_range(300) : $urandom_range(8);
				put_length(len);
				repeat (len) push_byte(8'($urandom_range(255)), 1'b0);
				if (cls == CLASS_UNIVERSAL && !cons && tag == 0 && len == 0 && depth > 0)
					depth--;
			end
		end
	endtask

	task automatic put_stream();
		int depth;
		depth = 0;
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(DEPTH_MAX_DEF, 1)) begin
				put_any_ident();
				push_byte(BYTE_80, 1'b0);
				depth++;
			end
		end
		repeat ($urandom_range(12, 1)) put_element(depth);
		while (depth > 0) begin
			push_byte(8'h00, 1'b0);
			push_byte(8'h00, 1'b0);
			depth--;
		end
		if ($urandom_range(3) != 0)
			end_stream();
	endtask

	task automatic put_failure();
		fail_kind_t  kind;
		int unsigned len;
		kind = fail_kind_t'($urandom_range(FAIL_TRUNC_OPEN));
		case (kind)
		FAIL_BAD_LEN: begin
			put_any_ident();
			push_byte(BYTE_FF, 1'b0);
		end
		FAIL_WIDE_TAG: begin
			push_byte({2'($urandom_range(3)), 1'($urandom_range(1)), TAG_LONG}, 1'b0);
			push_byte(BYTE_80 | 8'($urandom_range(127, 16)), 1'b0);
			repeat (3) push_byte(BYTE_80 | 8'($urandom_range(255)), 1'b0);
			push_byte(8'($urandom_range(255)), 1'b0);
		end
		FAIL_WIDE_LEN: begin
			put_any_ident();
			push_byte(BYTE_80 | 8'($urandom_range(126, 5)), 1'b0);
			push_byte(8'($urandom_range(255, 1)), 1'b0);
			repeat (4) push_byte(8'($urandom_range(255)), 1'b0);
		end
		FAIL_DEPTH: begin
			repeat (DEPTH_MAX_DEF + 1) begin
				put_any_ident();
				push_byte(BYTE_80, 1'b0);
			end
		end
		FAIL_TRUNC_HDR: begin
			put_any_ident();
			end_stream();
		end
		FAIL_TRUNC_BODY: begin
			put_any_ident();
			len = $urandom_range(20, 3);
			put_length(len);
			repeat ($urandom_range(len - 1)) push_byte(8'($urandom_range(255)), 1'b0);
			end_stream();
		end
		default: begin
			put_any_ident();
			push_byte(BYTE_80, 1'b0);
			end_stream();
		end
		endcase
		// sticky error: everything after must report the latched code
		repeat (20) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic settle();
		while (byte_q.size() != 0 || bin.valid || role_exp_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	int in_gap = 0;
	int in_seg = 0;
	int in_pct = 0;

	always @(posedge clk or negedge arst_n) begin
		beat_t nxt;
		if (!arst_n) begin
			bin.valid      <= 1'b0;
			bin.data_byte  <= '0;
			bin.stream_end <= 1'b0;
			in_gap = 0;
		end else begin
			if (bin.valid && bin.ready)
				role_exp_q.push_back(decode_byte(bin.data_byte, bin.stream_end));
			if (in_seg == 0) begin
				in_seg = 300;
				in_pct = idle_share();
			end else begin
				in_seg--;
			end
			if (!bin.valid || bin.ready) begin
				if (in_gap > 0) begin
					bin.valid <= 1'b0;
					in_gap--;
				end else if (!calm && bin.valid && $urandom_range(99) < in_pct) begin
					bin.valid <= 1'b0;
					in_gap = $urandom_range(16);
				end else if (byte_q.size() != 0) begin
					nxt = byte_q.pop_front();
					bin.valid      <= 1'b1;
					bin.data_byte  <= nxt.data_byte;
					bin.stream_end <= nxt.stream_end;
				end else begin
					bin.valid <= 1'b0;
				end
			end
		end
	end

	int out_stall = 0;
	int out_seg   = 0;
	int out_pct   = 0;
	int out_beats = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bout.ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (bout.valid && bout.ready)
				out_beats++;
			if (out_seg == 0) begin
				out_seg = 300;
				out_pct = idle_share();
			end else begin
				out_seg--;
			end
			if (!long_hold_done && out_beats >= LONG_HOLD_AT) begin
				long_hold_done = 1'b1;
				out_stall = LONG_HOLD_LEN;
			end
			if (out_stall > 0) begin
				bout.ready <= 1'b0;
				out_stall--;
			end else if (!calm && $urandom_range(99) < out_pct) begin
				bout.ready <= 1'b0;
				out_stall = $urandom_range(16);
			end else begin
				bout.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && bout.valid && bout.ready) begin
			if (role_exp_q.size() == 0) begin
				$error("result beat with no byte pending: role %0d", bout.byte_role);
				err_cnt++;
			end else begin
				want = role_exp_q.pop_front();
				check_field("byte_role", 32'(want.byte_role), 32'(bout.byte_role));
				check_field("header_done", 32'(want.header_done), 32'(bout.header_done));
				check_field("tag_class", 32'(want.tag_class), 32'(bout.tag_class));
				check_field("constructed", 32'(want.constructed), 32'(bout.constructed));
				check_field("tag_number", want.tag_number, bout.tag_number);
				check_field("content_length", want.content_length, bout.content_length);
				check_field("indefinite", 32'(want.indefinite), 32'(bout.indefinite));
				check_field("content_byte", 32'(want.content_byte), 32'(bout.content_byte));
				check_field("element_end", 32'(want.element_end), 32'(bout.element_end));
				check_field("nest_depth", 32'(want.nest_depth), 32'(bout.nest_depth));
				check_field("error_code", 32'(want.error_code), 32'(bout.error_code));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int start_n;
		arst_n          = 1'b0;
		bin.valid       = 1'b0;
		bin.data_byte   = '0;
		bin.stream_end  = 1'b0;
		bout.ready      = 1'b0;
		dec_phase       = PH_ID;
		dec_class       = '0;
		dec_cons        = 1'b0;
		dec_indef       = 1'b0;
		dec_tag         = '0;
		dec_len         = '0;
		dec_len_left    = '0;
		dec_remain      = '0;
		dec_depth       = 0;
		dec_err         = ERR_NONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty universal element at depth zero
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// private constructed, largest long-form tag, one content byte
		push_byte(8'hFF, 1'b0);
		push_byte(8'h8F, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFF, 1'b0);
		// indefinite sequence holding a long-form length with leading zeros
		push_byte(8'h30, 1'b0);
		push_byte(BYTE_80, 1'b0);
		push_byte(8'h04, 1'b0);
		push_byte(8'h84, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// long-form tag zero, empty, closes the stream cleanly
		push_byte(8'h5F, 1'b0);
		push_byte(BYTE_80, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		settle();

		start_n = bytes_pushed;
		while (bytes_pushed - start_n < RANDOM_BYTES)
			put_stream();
		while (byte_q.size() >= 200)
			@(posedge clk);
		calm = 1'b1;
		repeat (3) put_stream();
		put_failure();
		settle();
		repeat (12) @(posedge clk);

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
